// ----- rtl/apt_pkg.sv -----
// ----------------------------------------------------------------------------
// Application permission table package
// Shared types, field widths and codes for the permission table core.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int KEY_BITS     = 32;
    localparam int SANDBOX_BITS = 8;
    localparam int PERM_BITS    = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_GRANT    = 3'd1,
        OP_REVOKE   = 3'd2,
        OP_CHECK    = 3'd3,
        OP_PROMPT   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [SANDBOX_BITS-1:0] sandbox;
        logic [PERM_BITS-1:0]    granted;
        logic [PERM_BITS-1:0]    pending;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/apt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module apt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/apt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Permission table controller
// Sequences accept, table scan, entry update and result hand-off.
// ----------------------------------------------------------------------------
module apt_ctrl
    import apt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_RESULT;
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = i_s_tvalid;
            end
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            S_RESULT: o_cmd.load_out = i_status.out_free;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/apt_datapath.sv -----
// ----------------------------------------------------------------------------
// Permission table datapath
// Request registers, entry store, scan compare, update logic and result register.
// ----------------------------------------------------------------------------
module apt_datapath
    import apt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    output t_dp_status             o_status,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [2:0]              r_op;
    logic [KEY_BITS-1:0]     r_key;
    logic [SANDBOX_BITS-1:0] r_sandbox;
    logic [PERM_BITS-1:0]    r_perm;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]         r_addr;
    logic [IDX_W-1:0]         r_rd_idx;
    logic                     r_rd_vld;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    t_entry                   r_hit_entry;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_free_idx;

    t_status r_res_status;
    logic    r_res_answer;
    logic    r_out_valid;
    t_status r_out_status;
    logic    r_out_answer;

    logic [ENTRY_BITS-1:0] rd_word;
    t_entry                rd_entry;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    t_entry                wentry;
    logic                  set_valid;
    t_status               res_status;
    logic                  res_answer;
    logic                  held;
    logic                  perm_ok;
    logic                  rd_is_valid;

    apt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    assign rd_entry    = t_entry'(rd_word);
    assign rd_is_valid = r_valid[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_s_tuser;
            r_key     <= i_s_tdata[KEY_BITS-1:0];
            r_sandbox <= i_s_tdata[KEY_BITS +: SANDBOX_BITS];
            r_perm    <= i_s_tdata[KEY_BITS + SANDBOX_BITS +: PERM_BITS];
        end
        if (r_rd_vld && rd_is_valid && rd_entry.key == r_key && !r_hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_entry <= rd_entry;
        end
        if (r_rd_vld && !rd_is_valid && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        r_rd_idx <= r_addr;
        if (i_cmd.update) begin
            r_res_status <= res_status;
            r_res_answer <= res_answer;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_answer <= r_res_answer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_cmd.scan && r_addr != LAST_IDX) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_vld && rd_is_valid && rd_entry.key == r_key) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_vld && !rd_is_valid) begin
                    r_free_found <= 1'b1;
                end
            end
            if (set_valid) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        perm_ok    = (r_perm != '0);
        held       = ((r_hit_entry.granted & r_perm) == r_perm);
        we         = 1'b0;
        set_valid  = 1'b0;
        waddr      = r_hit_idx;
        wentry     = r_hit_entry;
        res_status = ST_INVALID;
        res_answer = 1'b0;
        case (r_op)
            OP_REGISTER: begin
                if (r_hit) begin
                    wentry.sandbox = r_sandbox;
                    we             = 1'b1;
                    res_status     = ST_OK;
                end else if (r_free_found) begin
                    waddr          = r_free_idx;
                    wentry.key     = r_key;
                    wentry.sandbox = r_sandbox;
                    wentry.granted = '0;
                    wentry.pending = '0;
                    we             = 1'b1;
                    set_valid      = 1'b1;
                    res_status     = ST_OK;
                end else begin
                    res_status = ST_FULL;
                end
            end
            OP_GRANT: begin
                if (r_hit && perm_ok) begin
                    wentry.granted = r_hit_entry.granted | r_perm;
                    wentry.pending = r_hit_entry.pending & ~r_perm;
                    we             = 1'b1;
                    res_status     = ST_OK;
                end
            end
            OP_REVOKE: begin
                if (r_hit && perm_ok) begin
                    wentry.granted = r_hit_entry.granted & ~r_perm;
                    we             = 1'b1;
                    res_status     = ST_OK;
                end
            end
            OP_CHECK: begin
                if (r_hit && perm_ok) begin
                    res_answer = held;
                    res_status = ST_OK;
                end
            end
            OP_PROMPT: begin
                if (r_hit && perm_ok) begin
                    res_status = ST_OK;
                    if (!held) begin
                        wentry.pending = r_hit_entry.pending | r_perm;
                        we             = 1'b1;
                        res_answer     = 1'b1;
                    end
                end
            end
            default: begin
                res_status = ST_INVALID;
            end
        endcase
        we        = we & i_cmd.update;
        set_valid = set_valid & i_cmd.update;
    end

    assign o_status.scan_last = (r_addr == LAST_IDX);
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - 3){1'b0}}, r_out_answer, r_out_status};

endmodule

// ----- rtl/app_permission_table_core.sv -----
// ----------------------------------------------------------------------------
// Application permission table core
// Keyed table of application entries with sandbox value and permission bits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream: tuser carries the operation, tdata
//   the key, sandbox value and permission mask. Each request gives exactly
//   one result on the master stream: status and answer.
//   A request scans every table entry through the entry RAM, one read per
//   cycle, then updates the matched or first free entry in one write.
//   After the scan the controller steps through drain, update and result;
//   a new request is taken only once it is back in idle, and the scan is
//   bounded by the single RAM read port.
//   The result sits in an output register, so the next request is taken
//   while it waits; a stalled receiver holds the result and blocks only
//   the hand-off of the following one.
//   Reset clears all entry valid bits and the output valid flag; entry
//   contents need no clearing.
// ----------------------------------------------------------------------------
module app_permission_table_core
    import apt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // app_key [31:0], sandbox_mode [39:32], perm_mask [55:40]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // op [2:0]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status [1:0], answer [2], zero [7:3]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    apt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    apt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- rtl/apt_checker.sv -----
// ----------------------------------------------------------------------------
// Permission table port checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module apt_checker
    import apt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while one is in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != ST_INVALID + ST_FULL)
        else $error("undefined status code");

    a_answer_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> o_m_tdata[1:0] == ST_OK)
        else $error("answer set with failing status");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind app_permission_table_core apt_checker u_apt_checker (.*);

// ----- verif/app_permission_table_checker.sv -----
// ----------------------------------------------------------------------------
// Application permission table checker
// Watches the request and result streams of the permission table core, keeps
// its own copy of the entry table, predicts the status and answer of every
// accepted request and compares them in order with the results that leave
// the core.
// ----------------------------------------------------------------------------
module app_permission_table_checker
    import apt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // app_key [31:0], sandbox_mode [39:32], perm_mask [55:40]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // op [2:0]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // status [1:0], answer [2], zero [7:3]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_status status;
        logic    answer;
    } t_reply;

    logic                    tbl_valid   [TABLE_ENTRIES];
    logic [KEY_BITS-1:0]     tbl_key     [TABLE_ENTRIES];
    logic [SANDBOX_BITS-1:0] tbl_sandbox [TABLE_ENTRIES];
    logic [PERM_BITS-1:0]    tbl_granted [TABLE_ENTRIES];
    logic [PERM_BITS-1:0]    tbl_pending [TABLE_ENTRIES];

    t_reply expected_replies[$];
    t_reply want;
    int     mismatches;

    function automatic t_reply apply_request(input logic [2:0]              op,
                                             input logic [KEY_BITS-1:0]     key,
                                             input logic [SANDBOX_BITS-1:0] sandbox,
                                             input logic [PERM_BITS-1:0]    mask);
        t_reply r;
        int     hit;
        int     slot;
        r.status = ST_INVALID;
        r.answer = 1'b0;
        hit      = -1;
        slot     = -1;
        // walk downwards so that the lowest matching and lowest free entries win
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_key[i] == key)
                hit = i;
            if (!tbl_valid[i])
                slot = i;
        end
        case (op)
            OP_REGISTER: begin
                if (hit >= 0) begin
                    tbl_sandbox[hit] = sandbox;
                    r.status = ST_OK;
                end else if (slot >= 0) begin
                    tbl_valid[slot]   = 1'b1;
                    tbl_key[slot]     = key;
                    tbl_sandbox[slot] = sandbox;
                    tbl_granted[slot] = '0;
                    tbl_pending[slot] = '0;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_GRANT, OP_REVOKE, OP_CHECK, OP_PROMPT: begin
                if (hit >= 0 && mask != '0) begin
                    r.status = ST_OK;
                    case (op)
                        OP_GRANT: begin
                            tbl_granted[hit] = tbl_granted[hit] | mask;
                            tbl_pending[hit] = tbl_pending[hit] & ~mask;
                        end
                        OP_REVOKE:
                            tbl_granted[hit] = tbl_granted[hit] & ~mask;
                        OP_CHECK:
                            r.answer = ((tbl_granted[hit] & mask) == mask);
                        default: begin
                            if ((tbl_granted[hit] & mask) != mask) begin
                                tbl_pending[hit] = tbl_pending[hit] | mask;
                                r.answer = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
                     exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            expected_replies.delete();
            mismatches = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("result with no request waiting", -1, int'(i_m_tdata));
                end else begin
                    want = expected_replies.pop_front();
                    if (i_m_tdata[1:0] != want.status)
                        report_mismatch("status", int'(want.status), int'(i_m_tdata[1:0]));
                    if (i_m_tdata[2] != want.answer)
                        report_mismatch("answer", int'(want.answer), int'(i_m_tdata[2]));
                    if (i_m_tdata[OUT_TDATA_W-1:3] != '0)
                        report_mismatch("padding", 0, int'(i_m_tdata[OUT_TDATA_W-1:3]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_replies.push_back(apply_request(
                    i_s_tuser,
                    i_s_tdata[KEY_BITS-1:0],
                    i_s_tdata[KEY_BITS +: SANDBOX_BITS],
                    i_s_tdata[KEY_BITS+SANDBOX_BITS +: PERM_BITS]));
        end
        o_outstanding <= expected_replies.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ----- verif/app_permission_table_core_test.sv -----
// ----------------------------------------------------------------------------
// Application permission table core testbench
// Drives directed and random register, grant, revoke, check and prompt
// requests, plus unused opcodes, into the core with bursty request flow and
// a stalling result receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module app_permission_table_core_test;

    import apt_pkg::*;

    localparam int TABLE_ENTRIES   = 16;
    localparam int KEY_POOL        = 20;
    localparam int RANDOM_REQUESTS = 1280;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 40;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_LONG_STALL
    } t_rx_mode;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int       fail_count;
    int       outstanding;
    int       burst_left  = 0;
    int       idle_cycles = 0;
    t_rx_mode rx_mode     = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_stall_left = 0;

    logic [KEY_BITS-1:0] app_keys [KEY_POOL];

    app_permission_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    app_permission_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:
                m_tready <= 1'b1;
            RX_RANDOM:
                m_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_stall_left == 0) begin
                    m_tready      <= 1'b1;
                    rx_stall_left <= $urandom_range(1, 40);
                end else begin
                    m_tready      <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL app_permission_table_core");
                $finish;
            end
        end
    end

    task automatic issue(input logic [2:0]              op,
                         input logic [KEY_BITS-1:0]     key,
                         input logic [SANDBOX_BITS-1:0] sandbox,
                         input logic [PERM_BITS-1:0]    mask);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {mask, sandbox, key};
        do @(posedge clk); while (!s_tready);
        // hold valid through a burst, drop it for a gap between bursts
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic random_request();
        logic [2:0]           op;
        logic [KEY_BITS-1:0]  key;
        logic [PERM_BITS-1:0] mask;
        int                   pick;
        pick = $urandom_range(0, 99);
        if (pick < 16)
            op = OP_REGISTER;
        else if (pick < 36)
            op = OP_GRANT;
        else if (pick < 50)
            op = OP_REVOKE;
        else if (pick < 72)
            op = OP_CHECK;
        else if (pick < 95)
            op = OP_PROMPT;
        else
            op = 3'($urandom_range(int'(OP_PROMPT) + 1, 2 ** IN_TUSER_W - 1));
        if ($urandom_range(0, 99) < 88)
            key = app_keys[$urandom_range(0, KEY_POOL - 1)];
        else
            key = $urandom;
        case ($urandom_range(0, 9))
            0:       mask = '0;
            1:       mask = '1;
            2, 3, 4: mask = PERM_BITS'(1) << $urandom_range(0, PERM_BITS - 1);
            5, 6:    mask = PERM_BITS'($urandom & $urandom & $urandom);
            default: mask = PERM_BITS'($urandom);
        endcase
        issue(op, key, SANDBOX_BITS'($urandom), mask);
    endtask

    initial begin
        logic [KEY_BITS-1:0] key_lo;
        logic [KEY_BITS-1:0] key_hi;
        logic [KEY_BITS-1:0] key_absent;
        key_lo     = '0;
        key_hi     = '1;
        key_absent = 32'h1234_5678;
        app_keys[0] = key_lo;
        app_keys[1] = key_hi;
        for (int i = 2; i < KEY_POOL; i++)
            app_keys[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_CHECK,    key_lo,     8'h00, 16'h0001);
        issue(OP_REGISTER, key_lo,     8'h00, 16'h0000);
        issue(OP_REGISTER, key_hi,     8'hFF, 16'hFFFF);
        issue(OP_REGISTER, key_lo,     8'h5A, 16'h1234);
        issue(OP_GRANT,    key_lo,     8'h00, 16'h0000);
        issue(OP_GRANT,    key_lo,     8'h00, 16'hFFFF);
        issue(OP_CHECK,    key_lo,     8'h00, 16'hFFFF);
        issue(OP_PROMPT,   key_lo,     8'h00, 16'h0001);
        issue(OP_REVOKE,   key_lo,     8'h00, 16'h00F0);
        issue(OP_CHECK,    key_lo,     8'h00, 16'h00FF);
        issue(OP_PROMPT,   key_lo,     8'h00, 16'h00F0);
        issue(OP_GRANT,    key_lo,     8'h00, 16'h0030);
        issue(OP_CHECK,    key_lo,     8'h00, 16'h0030);
        issue(OP_PROMPT,   key_hi,     8'hA5, 16'h8000);
        issue(OP_CHECK,    key_absent, 8'h00, 16'hFFFF);
        issue(OP_GRANT,    key_absent, 8'h00, 16'h0001);
        issue(OP_REVOKE,   key_hi,     8'h00, 16'hFFFF);
        issue(OP_PROMPT,   key_hi,     8'h00, 16'h0000);
        for (int u = int'(OP_PROMPT) + 1; u < 2 ** IN_TUSER_W; u++)
            issue(3'(u), key_lo, 8'hFF, 16'hFFFF);
        hold_until_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2)
                hold_until_drained();
            random_request();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS app_permission_table_core");
        else
            $display("FAIL app_permission_table_core");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/apt_pkg.sv
rtl/apt_ram.sv
rtl/apt_ctrl.sv
rtl/apt_datapath.sv
rtl/app_permission_table_core.sv
rtl/apt_checker.sv
verif/app_permission_table_checker.sv
verif/app_permission_table_core_test.sv
